/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SJF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SJF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sjf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_pkg
// Types and constants of the shortest-job-first ready queue.
// ----------------------------------------------------------------------------
package sjf_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;
  localparam int unsigned COUNT_OUT_W         = 5;

  typedef enum logic {
    OP_ENQ  = 1'b0,
    OP_PICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e         operation;
    logic [7:0]  process_id;
    logic [15:0] burst_remaining;
    logic [31:0] arrival_time;
  } in_t;

  typedef struct packed {
    status_e                  status;
    logic [7:0]               picked_id;
    logic [15:0]              picked_burst;
    logic [COUNT_OUT_W-1:0]   pending_count;
  } out_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] burst;
    logic [31:0] arrival;
  } entry_t;

endpackage

/* rtl/core/shortest_job_first_ready_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_job_first_ready_queue_top
// Ready queue ordered by remaining burst, then arrival time.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_i) takes one transaction: an
// enqueue of a process or a pick of the head. Output channel
// (out_valid_o/out_ready_i/out_o) returns exactly one result per input
// transaction, in order, with the count of waiting processes.
// Entries sit in a ring in one synchronous RAM. An enqueue walks from the
// tail towards the head, moving each entry that the new one precedes up by
// one slot, one entry per cycle through the RAM read/write ports.
// An enqueue answers once its walk ends, so its result comes later the further
// the walk goes; a pick first reads the head entry from the RAM; a full or
// empty rejection goes straight to the response.
// One transaction is in work at a time; in_ready_o rises at the edge that
// moves the result into the output register, so no new transaction is taken
// until the last result has left the sequencer.
// Reset empties the queue; no clearing pass is needed.
// While the receiver stalls, the result holds in the output register and a
// following result holds inside the sequencer, which then stops accepting.
// ----------------------------------------------------------------------------
module shortest_job_first_ready_queue_top #(
  parameter int unsigned QUEUE_DEPTH = sjf_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sjf_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sjf_pkg::out_t out_o
);
  import sjf_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  logic          rsp_valid;
  logic          rsp_ready;
  out_t          rsp;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;
  logic          out_valid_q;
  out_t          out_q;

  sjf_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_sjf_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  sjf_ram #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_sjf_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rsp_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* rtl/core/sjf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sjf_ram #(
  parameter int unsigned QUEUE_DEPTH = sjf_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] waddr_i,
  input  sjf_pkg::entry_t                wdata_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] raddr_i,
  output sjf_pkg::entry_t                rdata_o
);
  import sjf_pkg::*;

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sjf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_ctrl
// Sequencer: ring head and count, insertion walk from the tail, head pick.
// ----------------------------------------------------------------------------
module sjf_ctrl #(
  parameter int unsigned QUEUE_DEPTH = sjf_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sjf_pkg::in_t                   in_i,
  output logic                           rsp_valid_o,
  input  logic                           rsp_ready_i,
  output sjf_pkg::out_t                  rsp_o,
  output logic                           mem_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_waddr_o,
  output sjf_pkg::entry_t                mem_wdata_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_raddr_o,
  input  sjf_pkg::entry_t                mem_rdata_i
);
  import sjf_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW:0]   DepthExt = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DepthCnt = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(QUEUE_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMP   = 5'b00010,
    S_WRNEW = 5'b00100,
    S_PICK  = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] k_q, k_d;
  entry_t        new_q, new_d;
  out_t          res_q, res_d;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] cnt_dec;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = (CW + 1)'(head) + (CW + 1)'(idx);
    if (sum >= DepthExt) begin
      sum = sum - DepthExt;
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic goes_ahead(input entry_t cand, input entry_t e);
    logic res;
    if (cand.burst != e.burst) begin
      res = cand.burst < e.burst;
    end else begin
      res = cand.arrival < e.arrival;
    end
    return res;
  endfunction

  assign cnt_inc = count_q + CW'(1);
  assign cnt_dec = count_q - CW'(1);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    k_d         = k_q;
    new_d       = new_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_wdata_o = new_q;
    rd_idx      = cnt_dec;
    unique case (state_q)
      S_IDLE: begin
        rd_idx = (in_i.operation == OP_PICK) ? '0 : cnt_dec;
        if (in_valid_i) begin
          if (in_i.operation == OP_ENQ) begin
            new_d.id      = in_i.process_id;
            new_d.burst   = in_i.burst_remaining;
            new_d.arrival = in_i.arrival_time;
            if (count_q == DepthCnt) begin
              res_d   = '{status: ST_FULL, picked_id: '0, picked_burst: '0,
                          pending_count: COUNT_OUT_W'(count_q)};
              state_d = S_RESP;
            end else begin
              k_d     = count_q;
              state_d = (count_q == '0) ? S_WRNEW : S_CMP;
            end
          end else begin
            if (count_q == '0) begin
              res_d   = '{status: ST_EMPTY, picked_id: '0, picked_burst: '0,
                          pending_count: '0};
              state_d = S_RESP;
            end else begin
              state_d = S_PICK;
            end
          end
        end
      end
      S_CMP: begin
        rd_idx   = (k_q == CW'(1)) ? '0 : k_q - CW'(2);
        mem_we_o = 1'b1;
        if (goes_ahead(new_q, mem_rdata_i)) begin
          mem_wdata_o = mem_rdata_i;
          k_d         = k_q - CW'(1);
          if (k_q == CW'(1)) begin
            state_d = S_WRNEW;
          end
        end else begin
          mem_wdata_o = new_q;
          count_d     = cnt_inc;
          res_d       = '{status: ST_DONE, picked_id: '0, picked_burst: '0,
                          pending_count: COUNT_OUT_W'(cnt_inc)};
          state_d     = S_RESP;
        end
      end
      S_WRNEW: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = new_q;
        count_d     = cnt_inc;
        res_d       = '{status: ST_DONE, picked_id: '0, picked_burst: '0,
                        pending_count: COUNT_OUT_W'(cnt_inc)};
        state_d     = S_RESP;
      end
      S_PICK: begin
        res_d   = '{status: ST_DONE, picked_id: mem_rdata_i.id,
                    picked_burst: mem_rdata_i.burst,
                    pending_count: COUNT_OUT_W'(cnt_dec)};
        count_d = cnt_dec;
        head_d  = (head_q == LastSlot) ? '0 : head_q + AW'(1);
        state_d = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_waddr_o = slot_of(head_q, k_q);
  assign mem_raddr_o = slot_of(head_q, rd_idx);
  assign in_ready_o  = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign rsp_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    res_q <= res_d;
  end

endmodule

/* rtl/core/sjf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_checker
// Port-level checks of the ready queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sjf_checker #(
  parameter int unsigned QUEUE_DEPTH = sjf_pkg::DEFAULT_QUEUE_DEPTH
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input sjf_pkg::out_t out_i
);
  import sjf_pkg::*;

  `SJF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_i), "stalled result changed")
  `SJF_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "second transaction accepted while busy")
  `SJF_ASSERT_IMP(a_reject_zero, clk_i, rst_ni, out_valid_i && out_i.status != ST_DONE, out_i.picked_id == '0 && out_i.picked_burst == '0, "rejected result carries data")
  `SJF_ASSERT_IMP(a_full_count, clk_i, rst_ni, out_valid_i && out_i.status == ST_FULL, out_i.pending_count == COUNT_OUT_W'(QUEUE_DEPTH), "full result with wrong count")
  `SJF_ASSERT_IMP(a_empty_count, clk_i, rst_ni, out_valid_i && out_i.status == ST_EMPTY, out_i.pending_count == '0, "empty result with nonzero count")

endmodule

bind shortest_job_first_ready_queue_top sjf_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_sjf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_i       (out_o)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the shortest-job-first ready queue. A clocked
// driver feeds enqueue and pick transactions from a queue of pending items.
// A scoreboard keeps its own ordered ready list and works out the result of
// each accepted transaction. A clocked monitor compares every result
// field by field. Three phases vary idling on the input and output channels.
// ----------------------------------------------------------------------------
module testbench;
  import sjf_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = DEFAULT_QUEUE_DEPTH;
  localparam int unsigned PHASE_ITEMS  = 400;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_i        = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;

  in_t    pending[$];
  out_t   awaited[$];
  entry_t ready_list[$];
  out_t   due;
  int     send_idle_pct  = 32;
  int     recv_stall_pct = 75;
  int     error_count    = 0;
  logic   holding;

  shortest_job_first_ready_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic out_t schedule_outcome(in_t req);
    out_t res;
    int   pos;
    res = '0;
    res.status = ST_DONE;
    if (req.operation == OP_ENQ) begin
      if (ready_list.size() >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < ready_list.size() &&
               !(req.burst_remaining < ready_list[pos].burst ||
                 (req.burst_remaining == ready_list[pos].burst &&
                  req.arrival_time < ready_list[pos].arrival)))
          pos++;
        ready_list.insert(pos, entry_t'{req.process_id, req.burst_remaining,
                                        req.arrival_time});
      end
    end else if (ready_list.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.picked_id    = ready_list[0].id;
      res.picked_burst = ready_list[0].burst;
      void'(ready_list.pop_front());
    end
    res.pending_count = COUNT_OUT_W'(ready_list.size());
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void push_item(op_e op, logic [7:0] id, logic [15:0] burst,
                                    logic [31:0] arrival);
    in_t item;
    item.operation       = op;
    item.process_id      = id;
    item.burst_remaining = burst;
    item.arrival_time    = arrival;
    pending.push_back(item);
  endfunction

  function automatic void push_random_items(int count);
    int        enq_pct;
    op_e       op;
    logic [15:0] burst;
    logic [31:0] arrival;
    enq_pct = 55;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 80;
          1: enq_pct = 20;
          default: enq_pct = 55;
        endcase
      end
      op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_PICK;
      case ($urandom_range(3))
        0: burst = 16'($urandom_range(7));
        1: burst = 16'($urandom);
        2: burst = $urandom_range(1) ? 16'hffff : 16'h0000;
        default: burst = 16'($urandom_range(255));
      endcase
      case ($urandom_range(3))
        0: arrival = $urandom_range(3);
        1: arrival = $urandom;
        2: arrival = $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0000;
        default: arrival = $urandom_range(1023);
      endcase
      push_item(op, 8'($urandom), burst, arrival);
    end
  endfunction

  // Driver: predict on acceptance, then present the next transaction or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
    end else begin
      holding = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        awaited.push_back(schedule_outcome(in_i));
        holding = 1'b0;
      end
      if (!holding) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_i       <= pending.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, then stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_o), 32'd0);
        end else begin
          due = awaited.pop_front();
          if (out_o.status !== due.status)
            report_mismatch("status", 32'(out_o.status), 32'(due.status));
          if (out_o.picked_id !== due.picked_id)
            report_mismatch("picked_id", 32'(out_o.picked_id), 32'(due.picked_id));
          if (out_o.picked_burst !== due.picked_burst)
            report_mismatch("picked_burst", 32'(out_o.picked_burst),
                            32'(due.picked_burst));
          if (out_o.pending_count !== due.pending_count)
            report_mismatch("pending_count", 32'(out_o.pending_count),
                            32'(due.pending_count));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    // Directed: empty pick, extremes, ties, fill to overflow, drain a little.
    push_item(OP_PICK, 8'h00, 16'h0000, 32'h0000_0000);
    push_item(OP_ENQ, 8'hff, 16'hffff, 32'hffff_ffff);
    push_item(OP_ENQ, 8'h00, 16'h0000, 32'h0000_0000);
    push_item(OP_ENQ, 8'h01, 16'd5, 32'd10);
    push_item(OP_ENQ, 8'h02, 16'd5, 32'd10);
    push_item(OP_ENQ, 8'h03, 16'd5, 32'd9);
    push_item(OP_ENQ, 8'h04, 16'd4, 32'd100);
    push_item(OP_ENQ, 8'h05, 16'd5, 32'd11);
    push_item(OP_ENQ, 8'h06, 16'hffff, 32'h0000_0000);
    for (int i = 7; i < 16; i++)
      push_item(OP_ENQ, 8'(i), 16'h00aa + 16'(i % 3), 32'h5555_aaaa - 32'(i));
    push_item(OP_ENQ, 8'haa, 16'h0000, 32'h0000_0000);
    push_item(OP_PICK, 8'hff, 16'hffff, 32'hffff_ffff);
    push_item(OP_PICK, 8'h00, 16'h0000, 32'h0000_0000);
    push_item(OP_PICK, 8'h55, 16'h5555, 32'h5555_5555);
    push_item(OP_ENQ, 8'h5a, 16'd5, 32'd10);
    push_random_items(PHASE_ITEMS);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      if (phase != 0) push_random_items(PHASE_ITEMS);
      while (pending.size() != 0 || in_valid_i || awaited.size() != 0)
        @(posedge clk_i);
      if (phase == 0) begin
        send_idle_pct  = 75;
        recv_stall_pct = 32;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    end

    repeat (QUEUE_DEPTH + 8) @(posedge clk_i);
    if (error_count == 0 && awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
